@@ hdl/fhan_pkg.sv @@
// ----------------------------------------------------------------------------
// fhan_pkg
// widths, register codes and item types shared by the fhan pipeline
// ----------------------------------------------------------------------------
`default_nettype none
package fhan_pkg;

  localparam int FRAC_BITS = 16;
  localparam int R_W       = 31;
  localparam int H_W       = 17;
  localparam int X_W       = 32;
  localparam int HH_W      = 2 * H_W;
  localparam int XH_W      = X_W + H_W;
  localparam int A0_W      = XH_W - FRAC_BITS;
  localparam int Y_W       = A0_W + 1;
  localparam int D_W       = 33;
  localparam int BIG_W     = R_W + HH_W - FRAC_BITS;
  localparam int SMALL_W   = R_W + FRAC_BITS;
  localparam int T_W       = D_W + 4;
  localparam int TL_W      = 19;
  localparam int S_W       = 35;
  localparam int P_W       = 2 * S_W;
  localparam int REM_W     = S_W + 3;
  localparam int A_W       = 36;
  localparam int N_W       = 64;
  localparam int Q_W       = 31;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [R_W-1:0] SPEED_RST = 31'd6553600;
  localparam logic [H_W-1:0] STEP_RST  = 17'd655;

  localparam logic CFG_SPEED = 1'b0;
  localparam logic CFG_STEP  = 1'b1;

  typedef struct packed {
    logic [D_W-1:0]         d;
    logic [T_W-1:0]         t;
    logic signed [A0_W-1:0] a0;
    logic signed [Y_W-1:0]  y0;
    logic                   inband;
    logic                   degen;
    logic [R_W-1:0]         r;
  } fq_item_t;

  typedef struct packed {
    logic [D_W-1:0]         d;
    logic signed [A0_W-1:0] a0;
    logic signed [Y_W-1:0]  y0;
    logic                   inband;
    logic                   degen;
    logic [R_W-1:0]         r;
  } sq_side_t;

  typedef struct packed {
    logic           a_neg;
    logic           a_pos;
    logic           in2;
    logic           degen;
    logic [R_W-1:0] r;
    logic [D_W-1:0] d;
  } dv_side_t;

endpackage
`default_nettype wire

@@ hdl/fhan_front.sv @@
// ----------------------------------------------------------------------------
// fhan_front
// accepts input beats, forms d, a0 and y0 and classifies the band
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire [fhan_pkg::X_W-1:0] x1,
  input  wire [fhan_pkg::X_W-1:0] x2,
  input  wire [fhan_pkg::R_W-1:0] r,
  input  wire [fhan_pkg::H_W-1:0] h,
  input  wire                     q_full,
  output logic                    push,
  output fhan_pkg::fq_item_t      push_data
);
  import fhan_pkg::*;

  logic en;

  logic                   v1_r, v2_r, v3_r;
  logic [X_W-1:0]         x1_1_r;
  logic [R_W-1:0]         r1_r, r2_r, r3_r;
  logic [HH_W-1:0]        hh1_r;
  logic signed [XH_W-1:0] xh1_r;
  logic [BIG_W-1:0]       big2_r;
  logic [SMALL_W-1:0]     small2_r;
  logic signed [A0_W-1:0] a0_2_r, a0_3_r;
  logic signed [Y_W-1:0]  y0_2_r, y0_3_r;
  logic [D_W-1:0]         d3_r, ay3_r;

  logic [HH_W-1:0]        hh_nxt;
  logic signed [XH_W-1:0] xh_nxt;
  logic signed [A0_W-1:0] a0_nxt;
  logic signed [Y_W-1:0]  y0_nxt;
  logic [SMALL_W:0]       lo_sum;
  logic [D_W-1:0]         d_nxt;
  logic [Y_W-1:0]         ay_full;

  assign en       = !q_full;
  assign in_ready = en;
  assign push     = en && v3_r;

  assign hh_nxt = HH_W'(h) * HH_W'(h);
  assign xh_nxt = $signed({{(XH_W-X_W){x2[X_W-1]}}, x2}) * $signed({{(XH_W-H_W){1'b0}}, h});
  assign a0_nxt = $signed(xh1_r[XH_W-1:FRAC_BITS]);
  assign y0_nxt = $signed({{(Y_W-X_W){x1_1_r[X_W-1]}}, x1_1_r}) + $signed({a0_nxt[A0_W-1], a0_nxt});
  assign lo_sum = (SMALL_W+1)'({big2_r[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}})
                + (SMALL_W+1)'(small2_r);
  assign d_nxt  = D_W'(big2_r[BIG_W-1:FRAC_BITS]) + D_W'(lo_sum[SMALL_W:2*FRAC_BITS]);
  assign ay_full = y0_2_r[Y_W-1] ? Y_W'(-y0_2_r) : Y_W'(y0_2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_1_r   <= x1;
      r1_r     <= r;
      hh1_r    <= hh_nxt;
      xh1_r    <= xh_nxt;
      r2_r     <= r1_r;
      big2_r   <= BIG_W'(r1_r) * BIG_W'(hh1_r[HH_W-1:FRAC_BITS]);
      small2_r <= SMALL_W'(r1_r) * SMALL_W'(hh1_r[FRAC_BITS-1:0]);
      a0_2_r   <= a0_nxt;
      y0_2_r   <= y0_nxt;
      r3_r     <= r2_r;
      d3_r     <= d_nxt;
      a0_3_r   <= a0_2_r;
      y0_3_r   <= y0_2_r;
      ay3_r    <= ay_full[D_W-1:0];
    end
  end

  always_comb begin
    push_data.d      = d3_r;
    push_data.t      = T_W'(d3_r) + (T_W'(ay3_r) << 3);
    push_data.a0     = a0_3_r;
    push_data.y0     = y0_3_r;
    push_data.inband = ay3_r < d3_r;
    push_data.degen  = d3_r == '0;
    push_data.r      = r3_r;
  end

endmodule
`default_nettype wire

@@ hdl/fhan_queue.sv @@
// ----------------------------------------------------------------------------
// fhan_queue
// short queue between the front and back pipelines
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_queue #(
  parameter int DEPTH = fhan_pkg::QUEUE_DEPTH
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  fhan_pkg::fq_item_t push_data,
  output logic               full,
  input  wire                pop,
  output fhan_pkg::fq_item_t pop_data,
  output logic               empty
);
  import fhan_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fq_item_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

@@ hdl/fhan_isqrt.sv @@
// ----------------------------------------------------------------------------
// fhan_isqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_isqrt (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     en,
  input  wire                     in_valid,
  input  wire [fhan_pkg::P_W-1:0] p,
  input  fhan_pkg::sq_side_t      in_side,
  output logic                    out_valid,
  output logic [fhan_pkg::S_W-1:0] root,
  output fhan_pkg::sq_side_t      out_side
);
  import fhan_pkg::*;

  logic             v_r    [S_W];
  logic [REM_W-1:0] rem_r  [S_W];
  logic [S_W-1:0]   root_r [S_W];
  logic [P_W-1:0]   pr_r   [S_W];
  sq_side_t         side_r [S_W];

  for (genvar k = 0; k < S_W; k++) begin : g_st
    logic             v_i;
    logic [REM_W-1:0] rem_i, cur, trial;
    logic [S_W-1:0]   root_i;
    logic [P_W-1:0]   pr_i;
    sq_side_t         side_i;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign pr_i   = p;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign pr_i   = pr_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign cur   = {rem_i[REM_W-3:0], pr_i[P_W-1 -: 2]};
    assign trial = REM_W'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[k]  <= cur - trial;
          root_r[k] <= {root_i[S_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cur;
          root_r[k] <= {root_i[S_W-2:0], 1'b0};
        end
        pr_r[k]   <= pr_i << 2;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[S_W-1];
  assign root      = root_r[S_W-1];
  assign out_side  = side_r[S_W-1];

endmodule
`default_nettype wire

@@ hdl/fhan_div.sv @@
// ----------------------------------------------------------------------------
// fhan_div
// pipelined restoring divide r*|a|/d, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire                      in_valid,
  input  wire [fhan_pkg::N_W-1:0]  num,
  input  fhan_pkg::dv_side_t       in_side,
  output logic                     out_valid,
  output logic [fhan_pkg::Q_W-1:0] quot,
  output fhan_pkg::dv_side_t       out_side
);
  import fhan_pkg::*;

  logic           v_r    [Q_W];
  logic [D_W-1:0] rem_r  [Q_W];
  logic [Q_W-1:0] n_r    [Q_W];
  logic [Q_W-1:0] q_r    [Q_W];
  dv_side_t       side_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    logic           v_i;
    logic [D_W-1:0] rem_i;
    logic [Q_W-1:0] n_i, q_i;
    dv_side_t       side_i;
    logic [D_W:0]   cur, dv;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = num[N_W-1:Q_W];
      assign n_i    = num[Q_W-1:0];
      assign q_i    = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign n_i    = n_r[k-1];
      assign q_i    = q_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign cur = {rem_i, n_i[Q_W-1]};
    assign dv  = {1'b0, side_i.d};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= dv) begin
          rem_r[k] <= D_W'(cur - dv);
          q_r[k]   <= {q_i[Q_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= cur[D_W-1:0];
          q_r[k]   <= {q_i[Q_W-2:0], 1'b0};
        end
        n_r[k]    <= n_i << 1;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign quot      = q_r[Q_W-1];
  assign out_side  = side_r[Q_W-1];

endmodule
`default_nettype wire

@@ hdl/fhan_back.sv @@
// ----------------------------------------------------------------------------
// fhan_back
// takes classified items from the queue, runs root, blend and divide
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_back (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     q_empty,
  input  fhan_pkg::fq_item_t      q_data,
  output logic                    pop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [fhan_pkg::X_W-1:0] drive,
  output logic                    degenerate
);
  import fhan_pkg::*;

  localparam int PL_W = D_W + TL_W;
  localparam int PH_W = D_W + T_W - TL_W;

  logic en;

  logic            v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [PL_W-1:0] pl1_r;
  logic [PH_W-1:0] ph1_r;
  sq_side_t        s1_r, s2_r;
  logic [P_W-1:0]  p2_r;

  logic            sq_v;
  logic [S_W-1:0]  sq_root;
  sq_side_t        sq_side;

  logic signed [A_W-1:0] a3_r;
  sq_side_t              s3_r;
  logic [D_W-1:0]        nsel4_r;
  dv_side_t              s4_r;
  logic [N_W-1:0]        num5_r;
  dv_side_t              s5_r;

  logic            dv_v;
  logic [Q_W-1:0]  dv_q;
  dv_side_t        dv_side;

  logic                  out_valid_r, degen_r;
  logic [X_W-1:0]        drive_r;

  sq_side_t              s_in;
  logic [S_W-1:0]        diff;
  logic signed [A_W-1:0] a0x, y0x, hx, a_nxt;
  logic [A_W-1:0]        aa;
  logic                  in2;
  logic [X_W-1:0]        m32, r32, y_nxt;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && !q_empty;

  always_comb begin
    s_in.d      = q_data.d;
    s_in.a0     = q_data.a0;
    s_in.y0     = q_data.y0;
    s_in.inband = q_data.inband;
    s_in.degen  = q_data.degen;
    s_in.r      = q_data.r;
  end

  fhan_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .p         (p2_r),
    .in_side   (s2_r),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  assign diff = sq_root - S_W'(sq_side.d);
  assign a0x  = $signed({{(A_W-A0_W){sq_side.a0[A0_W-1]}}, sq_side.a0});
  assign y0x  = $signed({{(A_W-Y_W){sq_side.y0[Y_W-1]}}, sq_side.y0});
  assign hx   = $signed({{(A_W-S_W+1){1'b0}}, diff[S_W-1:1]});

  always_comb begin
    if (sq_side.inband) a_nxt = a0x + y0x;
    else if (sq_side.y0 > 0) a_nxt = a0x + hx;
    else a_nxt = a0x - hx;
  end

  assign aa  = a3_r[A_W-1] ? A_W'(-a3_r) : A_W'(a3_r);
  assign in2 = aa < A_W'(s3_r.d);

  fhan_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .num       (num5_r),
    .in_side   (s5_r),
    .out_valid (dv_v),
    .quot      (dv_q),
    .out_side  (dv_side)
  );

  assign m32 = {1'b0, dv_q};
  assign r32 = {1'b0, dv_side.r};

  always_comb begin
    if (dv_side.degen) y_nxt = '0;
    else if (dv_side.in2) y_nxt = dv_side.a_neg ? m32 : -m32;
    else y_nxt = dv_side.a_pos ? -r32 : r32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      v3_r        <= sq_v;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl1_r   <= PL_W'(q_data.d) * PL_W'(q_data.t[TL_W-1:0]);
      ph1_r   <= PH_W'(q_data.d) * PH_W'(q_data.t[T_W-1:TL_W]);
      s1_r    <= s_in;
      p2_r    <= P_W'(pl1_r) + (P_W'(ph1_r) << TL_W);
      s2_r    <= s1_r;
      a3_r    <= a_nxt;
      s3_r    <= sq_side;
      nsel4_r <= in2 ? aa[D_W-1:0] : '0;
      s4_r.a_neg <= a3_r < 0;
      s4_r.a_pos <= a3_r > 0;
      s4_r.in2   <= in2;
      s4_r.degen <= s3_r.degen;
      s4_r.r     <= s3_r.r;
      s4_r.d     <= s3_r.d;
      num5_r  <= N_W'(s4_r.r) * N_W'(nsel4_r);
      s5_r    <= s4_r;
      drive_r <= y_nxt;
      degen_r <= dv_side.degen;
    end
  end

  assign out_valid  = out_valid_r;
  assign drive      = drive_r;
  assign degenerate = degen_r;

endmodule
`default_nettype wire

@@ hdl/time_optimal_control_fhan.sv @@
// ----------------------------------------------------------------------------
// time_optimal_control_fhan
// second-order time-optimal synthesis (fhan) drive in signed Q16.16
// ----------------------------------------------------------------------------
// in_tdata carries position error x1 and rate error x2; each beat gives one
// out beat with the drive on out_tdata and the degenerate flag on out_tuser.
// cfg writes speed factor r (index 0) and step size h (index 1); cfg_ready is
// always high, write only while no beat is in flight.
// A new beat is taken every cycle while the queue is not full. With no stall
// a beat passes 3 front stages, the queue, 2 product stages, 35 square root
// stages (one root bit each), 3 blend stages, 31 divide stages (one quotient
// bit each) and the output register.
// The front pipeline stalls only while the 4-entry queue is full, so
// in_tready does not follow out_tready combinationally; when the receiver
// stalls, the back pipeline holds and the queue fills, then in_tready drops.
// Reset loads r = 100.0 and h = 655/65536 and empties both pipelines.
// ----------------------------------------------------------------------------
`default_nettype none
module time_optimal_control_fhan #(
  parameter int QUEUE_DEPTH = fhan_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // position_error[31:0], rate_error[63:32]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // drive[31:0]
  output logic        out_tuser,  // degenerate[0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire  [31:0] cfg_data
);
  import fhan_pkg::*;

  logic [R_W-1:0] speed_r;
  logic [H_W-1:0] step_r;

  logic     q_full, q_empty, push, pop;
  fq_item_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RST;
      step_r  <= STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPEED: speed_r <= cfg_data[R_W-1:0];
        CFG_STEP:  step_r  <= cfg_data[H_W-1:0];
        default: ;
      endcase
    end
  end

  fhan_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .x1        (in_tdata[31:0]),
    .x2        (in_tdata[63:32]),
    .r         (speed_r),
    .h         (step_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  fhan_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  fhan_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .drive      (out_tdata),
    .degenerate (out_tuser)
  );

endmodule
`default_nettype wire

@@ hdl/fhan_checker.sv @@
// ----------------------------------------------------------------------------
// fhan_checker
// port-level checks on the result channel and cfg_ready, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tuser,
  input wire        cfg_ready
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("degenerate beat with nonzero drive");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("cfg port not ready");

endmodule

bind time_optimal_control_fhan fhan_checker u_fhan_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire

@@ test/fhan_drive_checker.sv @@
// ----------------------------------------------------------------------------
// fhan_drive_checker
// watches the in, out and cfg channels of the fhan block, works out the drive
// and degenerate flag of every accepted in beat and compares each out beat
// with the oldest expected value
// ----------------------------------------------------------------------------
`default_nettype none
module fhan_drive_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [63:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [31:0] out_tdata,
  input  wire         out_tuser,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire         cfg_index,
  input  wire  [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  import fhan_pkg::*;

  typedef struct packed {
    logic [31:0] drive;
    logic        degenerate;
  } drive_beat_t;

  logic [R_W-1:0] speed_q;
  logic [H_W-1:0] step_q;
  drive_beat_t    drive_fifo[$];

  function automatic drive_beat_t fhan_drive(input logic signed [31:0] x1,
                                             input logic signed [31:0] x2);
    drive_beat_t res;
    logic [127:0] rr, hh, dd, prod, root, cand, m;
    longint a0, y0, a, yv;
    logic [63:0] ay, aa, half;
    rr = {97'b0, speed_q};
    hh = {111'b0, step_q};
    dd = (rr * hh * hh) >> (2 * FRAC_BITS);
    res = '0;
    if (dd == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    a0 = (longint'(x2) * longint'({47'b0, step_q})) >>> FRAC_BITS;
    y0 = longint'(x1) + a0;
    ay = (y0 < 0) ? -y0 : y0;
    if (ay < dd) begin
      a = a0 + y0;
    end else begin
      prod = dd * (dd + 8 * ay);
      root = 0;
      for (int b = 50; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= prod) root = cand;
      end
      half = (root - dd) >> 1;
      a = (y0 > 0) ? a0 + longint'(half) : a0 - longint'(half);
    end
    aa = (a < 0) ? -a : a;
    if (aa < dd) begin
      m = (rr * aa) / dd;
      yv = (a < 0) ? longint'(m[63:0]) : -longint'(m[63:0]);
    end else begin
      yv = (a > 0) ? -longint'(rr[63:0]) : longint'(rr[63:0]);
    end
    if (yv > 64'sd2147483647) yv = 64'sd2147483647;
    if (yv < -64'sd2147483648) yv = -64'sd2147483648;
    res.drive = yv[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    drive_beat_t want;
    if (!rst_n) begin
      speed_q <= SPEED_RST;
      step_q  <= STEP_RST;
      drive_fifo.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SPEED) speed_q <= cfg_data[R_W-1:0];
        else step_q <= cfg_data[H_W-1:0];
      end
      if (in_tvalid && in_tready) drive_fifo.push_back(fhan_drive(in_tdata[31:0], in_tdata[63:32]));
      if (out_tvalid && out_tready) begin
        if (drive_fifo.size() == 0) begin
          if (fail_count < 10) $display("unexpected out beat: drive %h flag %b", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = drive_fifo.pop_front();
          if (want.drive !== out_tdata || want.degenerate !== out_tuser) begin
            if (fail_count < 10)
              $display("drive mismatch: expected %h/%b got %h/%b",
                       want.drive, want.degenerate, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) pending_count <= drive_fifo.size();

endmodule
`default_nettype wire

@@ test/time_optimal_control_fhan_tb.sv @@
// ----------------------------------------------------------------------------
// time_optimal_control_fhan_tb
// drives error pairs through the fhan block under several r/h settings,
// with random gaps on both sides and one long receiver hold
// ----------------------------------------------------------------------------
`default_nettype none
module time_optimal_control_fhan_tb;
  import fhan_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_SPEED;
  logic [31:0] cfg_data = '0;
  int          fail_count, pending_count;
  int          out_beats = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 0;

  always #5 clk = ~clk;

  time_optimal_control_fhan dut (.*);

  fhan_drive_checker checker_i (.*);

  task automatic write_reg(input logic idx, input logic [31:0] val);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pair(input logic [31:0] x1, input logic [31:0] x2);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {x2, x1};
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  function automatic logic [31:0] rand_error();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 3))
      0: return v;
      1: return v >>> $urandom_range(8, 31);
      default: return v >>> $urandom_range(14, 26);
    endcase
  endfunction

  initial begin
    logic [31:0] speeds[8];
    logic [31:0] steps[8];
    speeds = '{32'd6553600, 32'hFFFF_FFFF, 32'd0, 32'd6553600,
               32'd1, 32'd65536, 32'd327680, 32'd2147483647};
    steps  = '{32'd655, 32'd65536, 32'd655, 32'd0,
               32'd1, 32'd65536, 32'd8192, 32'd131071};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        in_tvalid <= 1'b0;
        write_reg(CFG_SPEED, speeds[p]);
        write_reg(CFG_STEP, steps[p]);
      end
      send_pair(32'h0000_0000, 32'h0000_0000);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'h0000_0001);
      for (int i = 0; i < 145; i++) begin
        if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_pair(rand_error(), rand_error());
      end
      no_gaps = 0;
    end
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    int hold;
    @(posedge clk iff rst_n);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 12);
      if (out_beats == 300) hold = 400;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      out_beats++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
`default_nettype wire
